/* rtl/core/jdcal_pkg.sv */
// Package for the Julian Day to calendar date block.
// Holds the sequencer states, the multiplier operation codes, the fixed-point
// constants and the cumulative month table. No dependencies.
package jdcal_pkg;

	// Day number limits and epoch
	localparam logic [22:0] JD_MAX        = 23'd5373484;   // 9999 Dec 31
	localparam logic [23:0] JD_YEAR0_END  = 24'd1721425;   // 1 BC Dec 31
	localparam logic [8:0]  BC_YEAR_DAYS  = 9'd366;
	localparam logic [3:0]  YEAR_STEP_MAX = 4'd8;

	// Multiplier constants
	localparam logic [23:0] RECIP_YEAR    = 24'd11759221;  // round(2^32 / 365.2425)
	localparam logic [23:0] DAYS_PER_YEAR = 24'd365;
	localparam logic [23:0] RECIP_CENT    = 24'd5243;      // 2^19 / 100, rounded up
	localparam logic [23:0] RECIP_WEEK    = 24'd9586981;   // 2^26 / 7, rounded up

	localparam int MUL_A_W = 23;
	localparam int MUL_P_W = 47;

	typedef enum logic [1:0] {
		MUL_EST,
		MUL_WDAY,
		MUL_YEARDAYS,
		MUL_CENT
	} jdcal_mul_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EST,
		S_YEAR,
		S_WDAY,
		S_KSET,
		S_K365,
		S_K100,
		S_L100,
		S_BASE,
		S_DIFF,
		S_CHECK,
		S_MONTH,
		S_DAY,
		S_DONE
	} jdcal_state_t;

	// Days in a common year before the first day of month idx+1 (idx 0..12)
	function automatic logic [8:0] cum_days(input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd59;
			4'd3:    v = 9'd90;
			4'd4:    v = 9'd120;
			4'd5:    v = 9'd151;
			4'd6:    v = 9'd181;
			4'd7:    v = 9'd212;
			4'd8:    v = 9'd243;
			4'd9:    v = 9'd273;
			4'd10:   v = 9'd304;
			4'd11:   v = 9'd334;
			4'd12:   v = 9'd365;
			default: v = 9'd365;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/jdcal_mul.sv */
// Shared constant multiplier of the date block: one 23 x 24 bit product a cycle.
// The operation code picks the constant; the product is registered.
// Depends on jdcal_pkg.
module jdcal_mul import jdcal_pkg::*; (
	input  logic                clk,
	input  jdcal_mul_op_t       op,
	input  logic [MUL_A_W-1:0]  a,
	output logic [MUL_P_W-1:0]  prod
);

	logic [23:0]        b;
	logic [MUL_P_W-1:0] prod_q;

	// Select the constant operand
	always_comb begin
		case (op)
			MUL_EST:      b = RECIP_YEAR;
			MUL_WDAY:     b = RECIP_WEEK;
			MUL_YEARDAYS: b = DAYS_PER_YEAR;
			MUL_CENT:     b = RECIP_CENT;
			default:      b = RECIP_YEAR;
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

/* rtl/core/julian_day_to_calendar_date.sv */
// Converts one Julian Day number into the proleptic Gregorian year (negative
// for BC, no year 0), month, day of month and weekday (0 = Sunday). Inputs
// above 5373484 are treated as 5373484. One transaction is worked at a time by
// a sequencer around a single shared constant multiplier: the year estimate and
// weekday, then year trials (one or two in practice, at most nine), the month
// walk, and the day and done states to finish. A new transaction is accepted
// only once the finished conversion has been loaded into the output register,
// which a stalled earlier result can delay. A finished result waits in the output
// register while the next transaction is already accepted and worked.
// Depends on jdcal_pkg and jdcal_mul.
module julian_day_to_calendar_date import jdcal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [22:0]        day_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [2:0]         weekday
);

	jdcal_state_t       state_q, state_d;
	jdcal_mul_op_t      mul_op;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_P_W-1:0] prod;

	// Work registers
	logic [22:0]        jd_q;
	logic signed [23:0] x_q;
	logic signed [14:0] n_q;
	logic [2:0]         wd_q;
	logic [13:0]        k_q;
	logic [13:0]        m_q;
	logic [21:0]        acc_q;
	logic [6:0]         c_q;
	logic [21:0]        base_q;
	logic               leap_q;
	logic signed [23:0] d_q;
	logic [3:0]         steps_q;
	logic [3:0]         mi_q;
	logic [3:0]         mo_q;
	logic [4:0]         dom_q;

	// Output registers
	logic               out_valid_q;
	logic signed [14:0] year_q;
	logic [3:0]         month_q;
	logic [4:0]         day_q;
	logic [2:0]         weekday_q;

	// Combinational helpers
	logic               in_acc;
	logic               out_load;
	logic [22:0]        jd_sat;
	logic [22:0]        mag;
	logic [13:0]        q_est;
	logic [22:0]        jd_inc;
	logic [20:0]        q7;
	logic [2:0]         wd_rem;
	logic [6:0]         h_cent;
	logic [13:0]        h100;
	logic               leap_d;
	logic               in_year;
	logic signed [23:0] lim;
	logic               month_hit;
	logic signed [23:0] dom_full;

	jdcal_mul u_mul (
		.clk  (clk),
		.op   (mul_op),
		.a    (mul_a),
		.prod (prod)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign year      = year_q;
	assign month     = month_q;
	assign day       = day_q;
	assign weekday   = weekday_q;

	// Datapath helpers
	always_comb begin
		jd_sat   = (day_number > JD_MAX) ? JD_MAX : day_number;
		mag      = x_q[23] ? 23'(-x_q) : x_q[22:0];
		q_est    = prod[45:32];
		jd_inc   = jd_q + 23'd1;
		q7       = prod[46:26];
		wd_rem   = jd_inc[2:0] - 3'(q7[2:0] * 3'd7);
		h_cent   = prod[25:19];
		h100     = 14'({h_cent, 6'b0}) + 14'({h_cent, 5'b0}) + 14'({h_cent, 2'b0});
		leap_d   = (m_q[1:0] == 2'd0) && ((m_q != h100) || (h_cent[1:0] == 2'd0));
		in_year  = (d_q >= 24'sd1) && (d_q <= (leap_q ? 24'sd366 : 24'sd365));
		lim      = $signed({15'd0, cum_days(mi_q)})
		         + (((mi_q >= 4'd2) && leap_q) ? 24'sd1 : 24'sd0);
		month_hit = (d_q <= lim) || (mi_q == 4'd12);
		dom_full = d_q - $signed({15'd0, cum_days(mo_q - 4'd1)})
		         - (((mo_q >= 4'd3) && leap_q) ? 24'sd1 : 24'sd0);
	end

	// Next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_op  = MUL_EST;
		mul_a   = mag;
		case (state_q)
			S_IDLE:  if (in_acc) state_d = S_EST;
			S_EST: begin
				mul_op  = MUL_EST;
				mul_a   = mag;
				state_d = S_YEAR;
			end
			S_YEAR: begin
				mul_op  = MUL_WDAY;
				mul_a   = jd_inc;
				state_d = S_WDAY;
			end
			S_WDAY:  state_d = S_KSET;
			S_KSET:  state_d = S_K365;
			S_K365: begin
				mul_op  = MUL_YEARDAYS;
				mul_a   = 23'(k_q);
				state_d = S_K100;
			end
			S_K100: begin
				mul_op  = MUL_CENT;
				mul_a   = 23'(k_q);
				state_d = S_L100;
			end
			S_L100: begin
				mul_op  = MUL_CENT;
				mul_a   = 23'(m_q);
				state_d = S_BASE;
			end
			S_BASE:  state_d = S_DIFF;
			S_DIFF:  state_d = S_CHECK;
			S_CHECK: begin
				if (in_year || (steps_q == YEAR_STEP_MAX)) state_d = S_MONTH;
				else state_d = S_KSET;
			end
			S_MONTH: if (month_hit) state_d = S_DAY;
			S_DAY:   state_d = S_DONE;
			S_DONE:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					jd_q    <= jd_sat;
					x_q     <= $signed({1'b0, jd_sat}) - $signed(JD_YEAR0_END);
					steps_q <= 4'd0;
				end
			end
			S_YEAR: begin
				// Apply the sign of the offset; estimates for a non-negative offset, and a zero estimate, move up by one
				if (!x_q[23] || (q_est == 14'd0)) n_q <= $signed({1'b0, q_est}) + 15'sd1;
				else n_q <= -$signed({1'b0, q_est});
			end
			S_WDAY:  wd_q <= wd_rem;
			S_KSET: begin
				if (!n_q[14]) begin
					k_q <= (n_q == 15'sd0) ? 14'd0 : 14'(n_q - 15'sd1);
					m_q <= 14'(n_q);
				end else begin
					k_q <= 14'(~n_q);
					m_q <= 14'(~n_q);
				end
			end
			S_K100:  acc_q <= prod[21:0];
			S_L100:  c_q <= prod[25:19];
			S_BASE: begin
				leap_q <= leap_d;
				base_q <= acc_q + 22'(k_q >> 2) - 22'(c_q) + 22'(c_q >> 2);
			end
			S_DIFF: begin
				// Offset of the day within the trial year
				if (!n_q[14]) d_q <= x_q - $signed({2'b0, base_q});
				else d_q <= x_q + $signed({15'd0, BC_YEAR_DAYS}) + $signed({2'b0, base_q});
			end
			S_CHECK: begin
				if (in_year || (steps_q == YEAR_STEP_MAX)) begin
					mi_q <= 4'd1;
				end else begin
					steps_q <= steps_q + 4'd1;
					// Step the year, skipping year zero
					if (d_q < 24'sd1) n_q <= (n_q == 15'sd1) ? -15'sd1 : n_q - 15'sd1;
					else n_q <= (n_q == -15'sd1) ? 15'sd1 : n_q + 15'sd1;
				end
			end
			S_MONTH: begin
				if (month_hit) mo_q <= mi_q;
				else mi_q <= mi_q + 4'd1;
			end
			S_DAY:   dom_q <= dom_full[4:0];
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			year_q    <= n_q;
			month_q   <= mo_q;
			day_q     <= dom_q;
			weekday_q <= wd_q;
		end
	end

	// Checks
	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (steps_q <= YEAR_STEP_MAX))
		else $error("year trial count out of bounds");

	a_month_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MONTH) |-> ((mi_q >= 4'd1) && (mi_q <= 4'd12)))
		else $error("month walk index out of range");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result presented without a finished conversion");

	a_out_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((month_q >= 4'd1) && (month_q <= 4'd12)))
		else $error("result month out of range");

endmodule
